FILE: hw/rtl/ttb_pkg.sv
// shared types, constants and codes of the triangle tile binner
package ttb_pkg;

    localparam int FRACTION_BITS = 4;
    localparam int MAX_FRAME_DIM = 2048;
    localparam int MAX_TILE_ROWS = 64;

    localparam int VERT_W  = 21;
    localparam int ID_W    = 16;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W   = $clog2(MAX_FRAME_DIM);
    localparam int POS_W   = PIX_W + FRACTION_BITS;
    localparam int TILE_W  = $clog2(MAX_TILE_ROWS);
    localparam int STEP_W  = $clog2(TILE_W + 1);
    localparam int DSH_W   = CFG_W + TILE_W;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(768);
    localparam logic [CFG_W-1:0] TILE_SIZE_RST    = CFG_W'(32);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_TILE_SIZE    = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOX,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [PIX_W-1:0]   dividend;
        logic [CFG_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [TILE_W-1:0]  quotient;
    } t_div_rsp;

endpackage

FILE: hw/rtl/triangle_tile_binner.sv
// top level of the triangle tile binner
// Bins one triangle per transaction by its bounding box. After a triangle is taken, the S_BOX
// state clamps the vertices and forms the box; a triangle off screen then returns the block to
// idle with no results. Otherwise the four box edges go in turn through one shared restoring
// divider by tile_size, which finishes early when the quotient saturates at the grid edge; the
// rows then follow one a cycle while the output is not stalled. The input stays stalled until
// the last row is in the output register. Configuration writes are always ready and are meant
// for an idle block.
module triangle_tile_binner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ttb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ttb_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [ttb_pkg::VERT_W-1:0] i_vertex0_x,
    input  logic signed [ttb_pkg::VERT_W-1:0] i_vertex0_y,
    input  logic signed [ttb_pkg::VERT_W-1:0] i_vertex1_x,
    input  logic signed [ttb_pkg::VERT_W-1:0] i_vertex1_y,
    input  logic signed [ttb_pkg::VERT_W-1:0] i_vertex2_x,
    input  logic signed [ttb_pkg::VERT_W-1:0] i_vertex2_y,
    input  logic [ttb_pkg::ID_W-1:0]          i_triangle_id,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ttb_pkg::ID_W-1:0]          o_triangle_out_id,
    output logic [ttb_pkg::TILE_W-1:0]        o_tile_row,
    output logic [ttb_pkg::TILE_W-1:0]        o_first_tile_col,
    output logic [ttb_pkg::TILE_W-1:0]        o_last_tile_col,
    output logic                              o_row_is_last
);

    localparam logic [ttb_pkg::POS_W:0] CEIL_ADD = (ttb_pkg::POS_W+1)'((1 << ttb_pkg::FRACTION_BITS) - 1);

    function automatic logic [ttb_pkg::PIX_W-1:0] dim_m1(input logic [ttb_pkg::CFG_W-1:0] d);
        if (d == '0) begin
            return '0;
        end else if (32'(d) > ttb_pkg::MAX_FRAME_DIM) begin
            return ttb_pkg::PIX_W'(ttb_pkg::MAX_FRAME_DIM - 1);
        end else begin
            return ttb_pkg::PIX_W'(d - 1'b1);
        end
    endfunction

    function automatic logic [ttb_pkg::POS_W-1:0] clamp_pos(
        input logic signed [ttb_pkg::VERT_W-1:0] v,
        input logic [ttb_pkg::POS_W-1:0]         hi
    );
        if (v[ttb_pkg::VERT_W-1]) begin
            return '0;
        end else if (v[ttb_pkg::VERT_W-2:0] > (ttb_pkg::VERT_W-1)'(hi)) begin
            return hi;
        end else begin
            return v[ttb_pkg::POS_W-1:0];
        end
    endfunction

    function automatic logic [ttb_pkg::POS_W-1:0] min3(
        input logic [ttb_pkg::POS_W-1:0] a,
        input logic [ttb_pkg::POS_W-1:0] b,
        input logic [ttb_pkg::POS_W-1:0] c
    );
        logic [ttb_pkg::POS_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [ttb_pkg::POS_W-1:0] max3(
        input logic [ttb_pkg::POS_W-1:0] a,
        input logic [ttb_pkg::POS_W-1:0] b,
        input logic [ttb_pkg::POS_W-1:0] c
    );
        logic [ttb_pkg::POS_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    ttb_pkg::t_state                    r_state, n_state;
    logic [ttb_pkg::CFG_W-1:0]          r_frame_width;
    logic [ttb_pkg::CFG_W-1:0]          r_frame_height;
    logic [ttb_pkg::CFG_W-1:0]          r_tile_size;

    logic signed [ttb_pkg::VERT_W-1:0]  r_vx [3];
    logic signed [ttb_pkg::VERT_W-1:0]  r_vy [3];
    logic [ttb_pkg::ID_W-1:0]           r_id;
    logic [ttb_pkg::PIX_W-1:0]          r_pix [4];
    logic [ttb_pkg::TILE_W-1:0]         r_quo [4];
    logic [1:0]                         r_div_idx;
    logic [ttb_pkg::TILE_W-1:0]         r_row;

    logic                               r_out_valid;
    logic [ttb_pkg::ID_W-1:0]           r_out_id;
    logic [ttb_pkg::TILE_W-1:0]         r_out_row;
    logic [ttb_pkg::TILE_W-1:0]         r_out_first;
    logic [ttb_pkg::TILE_W-1:0]         r_out_last;
    logic                               r_out_is_last;

    logic [ttb_pkg::POS_W-1:0]          xmax, ymax;
    logic [ttb_pkg::POS_W-1:0]          cx [3];
    logic [ttb_pkg::POS_W-1:0]          cy [3];
    logic [ttb_pkg::POS_W-1:0]          min_x, max_x, min_y, max_y;
    logic [ttb_pkg::POS_W:0]            ceil_x, ceil_y;
    logic                               reject;
    logic                               in_acc;
    logic                               out_load;
    logic                               row_last;
    ttb_pkg::t_div_req                  div_req;
    ttb_pkg::t_div_rsp                  div_rsp;

    ttb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // box of the clamped vertices
    always_comb begin
        xmax = {dim_m1(r_frame_width), ttb_pkg::FRACTION_BITS'(0)};
        ymax = {dim_m1(r_frame_height), ttb_pkg::FRACTION_BITS'(0)};
        for (int i = 0; i < 3; i++) begin
            cx[i] = clamp_pos(r_vx[i], xmax);
            cy[i] = clamp_pos(r_vy[i], ymax);
        end
        min_x  = min3(cx[0], cx[1], cx[2]);
        max_x  = max3(cx[0], cx[1], cx[2]);
        min_y  = min3(cy[0], cy[1], cy[2]);
        max_y  = max3(cy[0], cy[1], cy[2]);
        ceil_x = {1'b0, max_x} + CEIL_ADD;
        ceil_y = {1'b0, max_y} + CEIL_ADD;
        reject = (min_x >= xmax) || (max_x == '0) || (min_y >= ymax) || (max_y == '0);
    end

    always_comb begin
        n_state          = r_state;
        in_acc           = 1'b0;
        out_load         = 1'b0;
        row_last         = (r_row == r_quo[3]);
        div_req.start    = 1'b0;
        div_req.dividend = r_pix[r_div_idx];
        div_req.divisor  = (r_tile_size == '0) ? ttb_pkg::CFG_W'(1) : r_tile_size;
        unique case (r_state)
            ttb_pkg::S_IDLE: begin
                in_acc = i_in_valid;
                if (i_in_valid) begin
                    n_state = ttb_pkg::S_BOX;
                end
            end
            ttb_pkg::S_BOX: begin
                n_state = reject ? ttb_pkg::S_IDLE : ttb_pkg::S_DIV_START;
            end
            ttb_pkg::S_DIV_START: begin
                div_req.start = 1'b1;
                n_state       = ttb_pkg::S_DIV_WAIT;
            end
            ttb_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_div_idx == 2'd3) ? ttb_pkg::S_EMIT : ttb_pkg::S_DIV_START;
                end
            end
            ttb_pkg::S_EMIT: begin
                out_load = !r_out_valid || !i_out_stall;
                if (out_load && row_last) begin
                    n_state = ttb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ttb_pkg::FRAME_WIDTH_RST;
            r_frame_height <= ttb_pkg::FRAME_HEIGHT_RST;
            r_tile_size    <= ttb_pkg::TILE_SIZE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ttb_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                ttb_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                ttb_pkg::CFG_TILE_SIZE:    r_tile_size    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_idx <= '0;
        end else if (r_state == ttb_pkg::S_BOX) begin
            r_div_idx <= '0;
        end else if (r_state == ttb_pkg::S_DIV_WAIT && div_rsp.done) begin
            r_div_idx <= r_div_idx + 1'b1;
        end
    end

    // payload of the transaction in flight
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_vx[0] <= i_vertex0_x;
            r_vy[0] <= i_vertex0_y;
            r_vx[1] <= i_vertex1_x;
            r_vy[1] <= i_vertex1_y;
            r_vx[2] <= i_vertex2_x;
            r_vy[2] <= i_vertex2_y;
            r_id    <= i_triangle_id;
        end
        if (r_state == ttb_pkg::S_BOX) begin
            r_pix[0] <= min_x[ttb_pkg::POS_W-1:ttb_pkg::FRACTION_BITS];
            r_pix[1] <= min_y[ttb_pkg::POS_W-1:ttb_pkg::FRACTION_BITS];
            r_pix[2] <= ceil_x[ttb_pkg::POS_W-1:ttb_pkg::FRACTION_BITS];
            r_pix[3] <= ceil_y[ttb_pkg::POS_W-1:ttb_pkg::FRACTION_BITS];
        end
        if (r_state == ttb_pkg::S_DIV_WAIT && div_rsp.done) begin
            r_quo[r_div_idx] <= div_rsp.quotient;
        end
        if (r_state == ttb_pkg::S_DIV_WAIT && div_rsp.done && r_div_idx == 2'd3) begin
            r_row <= r_quo[1];
        end else if (out_load) begin
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id      <= r_id;
            r_out_row     <= r_row;
            r_out_first   <= r_quo[0];
            r_out_last    <= r_quo[2];
            r_out_is_last <= row_last;
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_in_stall        = (r_state != ttb_pkg::S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_triangle_out_id = r_out_id;
    assign o_tile_row        = r_out_row;
    assign o_first_tile_col  = r_out_first;
    assign o_last_tile_col   = r_out_last;
    assign o_row_is_last     = r_out_is_last;

endmodule

FILE: hw/rtl/ttb_div.sv
// restoring divider, one quotient bit a cycle, quotient saturated to the tile grid
module ttb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttb_pkg::t_div_req i_req,
    output ttb_pkg::t_div_rsp o_rsp
);

    localparam logic [ttb_pkg::STEP_W-1:0] TOP_STEP = ttb_pkg::STEP_W'(ttb_pkg::TILE_W);

    logic                          r_busy;
    logic [ttb_pkg::STEP_W-1:0]    r_step;
    logic [ttb_pkg::PIX_W-1:0]     r_rem;
    logic [ttb_pkg::CFG_W-1:0]     r_dvs;
    logic [ttb_pkg::TILE_W-1:0]    r_quo;

    logic [ttb_pkg::DSH_W-1:0]     dsh;
    logic                          ge;
    logic [ttb_pkg::TILE_W-1:0]    quo_bit;

    always_comb begin
        dsh     = ttb_pkg::DSH_W'(r_dvs) << r_step;
        ge      = ttb_pkg::DSH_W'(r_rem) >= dsh;
        quo_bit = ttb_pkg::TILE_W'(1) << r_step;
        o_rsp.done     = r_busy && ((r_step == TOP_STEP && ge) || r_step == '0);
        if (r_step == TOP_STEP) begin
            o_rsp.quotient = '1;
        end else begin
            o_rsp.quotient = ge ? (r_quo | quo_bit) : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= TOP_STEP;
        end else if (r_busy) begin
            if (o_rsp.done) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy && r_step != TOP_STEP && ge) begin
            r_rem <= r_rem - dsh[ttb_pkg::PIX_W-1:0];
            r_quo <= r_quo | quo_bit;
        end
    end

endmodule

FILE: hw/rtl/ttb_checker.sv
// port checker of the triangle tile binner and its bind
module ttb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [ttb_pkg::ID_W-1:0]          o_triangle_out_id,
    input logic [ttb_pkg::TILE_W-1:0]        o_tile_row,
    input logic [ttb_pkg::TILE_W-1:0]        o_first_tile_col,
    input logic [ttb_pkg::TILE_W-1:0]        o_last_tile_col,
    input logic                              o_row_is_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_triangle_out_id) && $stable(o_tile_row)
            && $stable(o_first_tile_col) && $stable(o_last_tile_col)
            && $stable(o_row_is_last)))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("ready again straight after a transaction");

    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_stall) |-> o_row_is_last)
        else $error("idle while rows of a triangle remain");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_first_tile_col <= o_last_tile_col))
        else $error("column span reversed");

endmodule

bind triangle_tile_binner ttb_checker u_ttb_checker (.*);

FILE: sim/ttb_checker.sv
`timescale 1ns / 100ps
// checker for the triangle tile binner: watches all channels, predicts the row results and compares
module tb_checker
    import ttb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic signed [VERT_W-1:0] i_vertex0_x,
    input  logic signed [VERT_W-1:0] i_vertex0_y,
    input  logic signed [VERT_W-1:0] i_vertex1_x,
    input  logic signed [VERT_W-1:0] i_vertex1_y,
    input  logic signed [VERT_W-1:0] i_vertex2_x,
    input  logic signed [VERT_W-1:0] i_vertex2_y,
    input  logic [ID_W-1:0]        i_triangle_id,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [ID_W-1:0]        i_triangle_out_id,
    input  logic [TILE_W-1:0]      i_tile_row,
    input  logic [TILE_W-1:0]      i_first_tile_col,
    input  logic [TILE_W-1:0]      i_last_tile_col,
    input  logic                   i_row_is_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_rows_seen,
    output int                     o_rejected
);

    localparam int ONE = 1 << FRACTION_BITS;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TILE_W-1:0] row;
        logic [TILE_W-1:0] first_col;
        logic [TILE_W-1:0] last_col;
        logic              is_last;
    } t_row_span;

    t_row_span        row_span_q [$];
    t_row_span        want;
    logic [CFG_W-1:0] frame_w;
    logic [CFG_W-1:0] frame_h;
    logic [CFG_W-1:0] tile_sz;
    int               fails = 0;
    int               rows_seen = 0;
    int               rejects = 0;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int sat_dim(input int d);
        return clamp_int(d, 1, MAX_FRAME_DIM);
    endfunction

    function automatic int grid_count(input int dim, input int ts);
        return clamp_int((dim + ts - 1) / ts, 1, MAX_TILE_ROWS);
    endfunction

    function automatic int min3(input int a, input int b, input int c);
        int m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic int max3(input int a, input int b, input int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    task automatic bin_triangle(input int x0, input int y0, input int x1, input int y1,
                                input int x2, input int y2, input logic [ID_W-1:0] id);
        int        w, h, ts, xmax, ymax, cols, rows;
        int        min_x, max_x, min_y, max_y, c0, c1, r0, r1;
        t_row_span row_span;
        w    = sat_dim(int'(frame_w));
        h    = sat_dim(int'(frame_h));
        ts   = (tile_sz == '0) ? 1 : int'(tile_sz);
        xmax = (w - 1) * ONE;
        ymax = (h - 1) * ONE;
        cols = grid_count(w, ts);
        rows = grid_count(h, ts);
        x0 = clamp_int(x0, 0, xmax);
        x1 = clamp_int(x1, 0, xmax);
        x2 = clamp_int(x2, 0, xmax);
        y0 = clamp_int(y0, 0, ymax);
        y1 = clamp_int(y1, 0, ymax);
        y2 = clamp_int(y2, 0, ymax);
        min_x = min3(x0, x1, x2);
        max_x = max3(x0, x1, x2);
        min_y = min3(y0, y1, y2);
        max_y = max3(y0, y1, y2);
        if (min_x >= xmax || max_x <= 0 || min_y >= ymax || max_y <= 0) begin
            rejects++;
            return;
        end
        c0 = clamp_int((min_x / ONE) / ts, 0, cols - 1);
        r0 = clamp_int((min_y / ONE) / ts, 0, rows - 1);
        c1 = clamp_int(((max_x + ONE - 1) / ONE) / ts, 0, cols - 1);
        r1 = clamp_int(((max_y + ONE - 1) / ONE) / ts, 0, rows - 1);
        for (int r = r0; r <= r1; r++) begin
            row_span.id        = id;
            row_span.row       = TILE_W'(r);
            row_span.first_col = TILE_W'(c0);
            row_span.last_col  = TILE_W'(c1);
            row_span.is_last   = (r == r1);
            row_span_q = {row_span_q, row_span};
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_w = FRAME_WIDTH_RST;
            frame_h = FRAME_HEIGHT_RST;
            tile_sz = TILE_SIZE_RST;
            row_span_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FRAME_WIDTH:  frame_w = i_cfg_data;
                    CFG_FRAME_HEIGHT: frame_h = i_cfg_data;
                    CFG_TILE_SIZE:    tile_sz = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                rows_seen++;
                if (row_span_q.size() == 0) begin
                    $error("unexpected tile row result: id %0d row %0d",
                           i_triangle_out_id, i_tile_row);
                    fails++;
                end else begin
                    want = row_span_q.pop_front();
                    if (i_triangle_out_id !== want.id) begin
                        $error("triangle_out_id expected %0d actual %0d",
                               want.id, i_triangle_out_id);
                        fails++;
                    end
                    if (i_tile_row !== want.row) begin
                        $error("tile_row expected %0d actual %0d", want.row, i_tile_row);
                        fails++;
                    end
                    if (i_first_tile_col !== want.first_col) begin
                        $error("first_tile_col expected %0d actual %0d",
                               want.first_col, i_first_tile_col);
                        fails++;
                    end
                    if (i_last_tile_col !== want.last_col) begin
                        $error("last_tile_col expected %0d actual %0d",
                               want.last_col, i_last_tile_col);
                        fails++;
                    end
                    if (i_row_is_last !== want.is_last) begin
                        $error("row_is_last expected %0d actual %0d",
                               want.is_last, i_row_is_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                bin_triangle(int'(i_vertex0_x), int'(i_vertex0_y), int'(i_vertex1_x),
                             int'(i_vertex1_y), int'(i_vertex2_x), int'(i_vertex2_y),
                             i_triangle_id);
            end
        end
        o_fail_count <= fails;
        o_pending    <= row_span_q.size();
        o_rows_seen  <= rows_seen;
        o_rejected   <= rejects;
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// testbench top for the triangle tile binner: stimulus, handshake idling and verdict
module tb;
    import ttb_pkg::*;

    localparam int ONE            = 1 << FRACTION_BITS;
    localparam int QUIET_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int V_MIN          = -(1 << (VERT_W - 1));
    localparam int V_MAX          = (1 << (VERT_W - 1)) - 1;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_valid   = 1'b0;
    t_cfg_idx                i_cfg_index   = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]        i_cfg_data    = '0;
    logic                    i_in_valid    = 1'b0;
    logic signed [VERT_W-1:0] i_vertex0_x  = '0;
    logic signed [VERT_W-1:0] i_vertex0_y  = '0;
    logic signed [VERT_W-1:0] i_vertex1_x  = '0;
    logic signed [VERT_W-1:0] i_vertex1_y  = '0;
    logic signed [VERT_W-1:0] i_vertex2_x  = '0;
    logic signed [VERT_W-1:0] i_vertex2_y  = '0;
    logic [ID_W-1:0]         i_triangle_id = '0;
    logic                    i_out_stall   = 1'b0;

    logic                    o_cfg_ready;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [ID_W-1:0]         o_triangle_out_id;
    logic [TILE_W-1:0]       o_tile_row;
    logic [TILE_W-1:0]       o_first_tile_col;
    logic [TILE_W-1:0]       o_last_tile_col;
    logic                    o_row_is_last;

    int fail_count;
    int pending_rows;
    int rows_seen;
    int rejected_count;

    int triangles_sent = 0;
    int settings_used  = 1;
    int burst_left     = 1;
    bit in_valid_up    = 1'b0;
    int frame_w_pix    = 1024;
    int frame_h_pix    = 768;
    int stall_mode     = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;

    always #5 i_clk = ~i_clk;

    triangle_tile_binner u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_vertex0_x       (i_vertex0_x),
        .i_vertex0_y       (i_vertex0_y),
        .i_vertex1_x       (i_vertex1_x),
        .i_vertex1_y       (i_vertex1_y),
        .i_vertex2_x       (i_vertex2_x),
        .i_vertex2_y       (i_vertex2_y),
        .i_triangle_id     (i_triangle_id),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_triangle_out_id (o_triangle_out_id),
        .o_tile_row        (o_tile_row),
        .o_first_tile_col  (o_first_tile_col),
        .o_last_tile_col   (o_last_tile_col),
        .o_row_is_last     (o_row_is_last)
    );

    tb_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_vertex0_x       (i_vertex0_x),
        .i_vertex0_y       (i_vertex0_y),
        .i_vertex1_x       (i_vertex1_x),
        .i_vertex1_y       (i_vertex1_y),
        .i_vertex2_x       (i_vertex2_x),
        .i_vertex2_y       (i_vertex2_y),
        .i_triangle_id     (i_triangle_id),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_triangle_out_id (o_triangle_out_id),
        .i_tile_row        (o_tile_row),
        .i_first_tile_col  (o_first_tile_col),
        .i_last_tile_col   (o_last_tile_col),
        .i_row_is_last     (o_row_is_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending_rows),
        .o_rows_seen       (rows_seen),
        .o_rejected        (rejected_count)
    );

    // receiver stall pattern, a random mode held until its countdown runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 99) < 30);
            2:       i_out_stall <= ($urandom_range(0, 99) < 70);
            default: i_out_stall <= (stall_left[1:0] == 2'd0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_tri(input int x0, input int y0, input int x1, input int y1,
                            input int x2, input int y2, input int id);
        i_in_valid    <= 1'b1;
        in_valid_up    = 1'b1;
        i_vertex0_x   <= VERT_W'(x0);
        i_vertex0_y   <= VERT_W'(y0);
        i_vertex1_x   <= VERT_W'(x1);
        i_vertex1_y   <= VERT_W'(y1);
        i_vertex2_x   <= VERT_W'(x2);
        i_vertex2_y   <= VERT_W'(y2);
        i_triangle_id <= ID_W'(id);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        triangles_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            in_valid_up = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic drain_results;
        if (in_valid_up) begin
            i_in_valid <= 1'b0;
            in_valid_up = 1'b0;
        end
        @(posedge i_clk);
        while (pending_rows != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int fw, input int fh, input int tsz);
        drain_results();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_TILE_SIZE, tsz);
        i_cfg_valid <= 1'b0;
        frame_w_pix = (fw < 1) ? 1 : (fw > MAX_FRAME_DIM) ? MAX_FRAME_DIM : fw;
        frame_h_pix = (fh < 1) ? 1 : (fh > MAX_FRAME_DIM) ? MAX_FRAME_DIM : fh;
        settings_used++;
    endtask

    function automatic int screen_pos(input int dim);
        return int'($urandom_range(0, (dim + 8) * ONE)) - 4 * ONE;
    endfunction

    function automatic int near_pos(input int centre, input int radius);
        return centre + int'($urandom_range(0, 2 * radius)) - radius;
    endfunction

    function automatic int raw_pos();
        return int'($urandom_range(0, (1 << VERT_W) - 1)) + V_MIN;
    endfunction

    task automatic send_random_tri;
        int pick, cx, cy, radius;
        int v [6];
        pick = $urandom_range(0, 99);
        cx   = screen_pos(frame_w_pix);
        cy   = screen_pos(frame_h_pix);
        case ($urandom_range(0, 3))
            0:       radius = ONE;
            1:       radius = 16 * ONE;
            2:       radius = 256 * ONE;
            default: radius = frame_w_pix * ONE;
        endcase
        for (int k = 0; k < 3; k++) begin
            if (pick < 60) begin
                v[2*k]   = near_pos(cx, radius);
                v[2*k+1] = near_pos(cy, radius);
            end else if (pick < 85) begin
                v[2*k]   = screen_pos(frame_w_pix);
                v[2*k+1] = screen_pos(frame_h_pix);
            end else begin
                v[2*k]   = raw_pos();
                v[2*k+1] = raw_pos();
            end
        end
        send_tri(v[0], v[1], v[2], v[3], v[4], v[5], $urandom_range(0, 65535));
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 4) drain_results();
            send_random_tri();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset frame 1024x768, tile 32
        send_tri(16, 16, 160, 16, 16, 160, 0);
        send_tri(V_MIN, V_MIN, V_MAX, V_MIN, 0, V_MAX, 16'hFFFF);
        drain_results();
        send_tri(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, 1);
        send_tri(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, 2);
        send_tri(-16, 100, -500, 2000, 0, 3000, 3);
        send_tri(100, 0, 2000, -5, 3000, -1000, 4);
        send_tri(16368, 100, 20000, 200, 17000, 300, 5);
        send_tri(100, 12272, 200, 13000, 300, 99999, 6);
        send_tri(16367, 12271, 16368, 12272, 16368, 12272, 7);
        send_tri(0, 0, 1, 1, 0, 1, 8);
        send_tri(0, 0, 31 * ONE + 1, 0, 0, 31 * ONE + 1, 9);
        send_tri(5000, 5000, 5000, 5000, 5000, 5000, 10);
        send_tri(-100, 4000, 20000, 4000, 5000, 4000, 11);
        send_tri(8000, -100, 8000, 20000, 8000, 6000, 12);
        send_tri(699050, -699051, 699050, -699051, 699050, -699051, 16'hA5A5);
        send_tri(-699051, 699050, -699051, 699050, -699051, 699050, 16'h5A5A);
        send_tri(31 * ONE, 31 * ONE, 32 * ONE, 32 * ONE, 33 * ONE - 1, 0, 13);
        send_tri(15, 15, 16, 16, 17, 17, 14);
        run_random(42);

        apply_setting(2048, 2048, 32);
        run_random(25);
        apply_setting(2048, 2048, 2048);
        run_random(20);
        apply_setting(1, 1, 32);
        run_random(10);
        apply_setting(4095, 4095, 4095);
        run_random(20);
        apply_setting(0, 0, 0);
        run_random(15);
        apply_setting(640, 480, 1);
        run_random(30);
        apply_setting(100, 37, 33);
        run_random(30);
        apply_setting(1920, 1080, 64);
        run_random(30);
        apply_setting(1024, 768, 32);
        run_random(30);

        drain_results();
        repeat (QUIET_CYCLES) @(posedge i_clk);

        $display("covered %0d triangles under %0d frame and tile settings",
                 triangles_sent, settings_used);
        $display("%0d tile row results checked, %0d triangles rejected off screen",
                 rows_seen, rejected_count);
        if (fail_count == 0 && pending_rows == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
